// ===== rtl/core/gj_pkg.sv =====
// shared types, constants and state codes for the gauss-jordan inverse block
// no dependencies
`timescale 1ns / 1ps

package gj_pkg;

   localparam int DEF_MAX_SIZE = 8;
   localparam logic [3:0] DEF_MATRIX_SIZE = 4'd8;
   localparam int FIELD_IDX_W = 3;

   localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
   localparam logic signed [31:0] Q_ZERO = 32'sh0000_0000;
   localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic [FIELD_IDX_W-1:0] entry_row;
      logic [FIELD_IDX_W-1:0] entry_col;
      logic signed [31:0] entry_value;
      logic last_entry;
   } req_type;

   typedef struct packed {
      logic [FIELD_IDX_W-1:0] out_row;
      logic [FIELD_IDX_W-1:0] out_col;
      logic signed [31:0] out_value;
      logic zero_pivot;
      logic last_result;
   } rsp_type;

   // one word of the working store: matrix entry and inverse entry side by side
   typedef struct packed {
      logic signed [31:0] a_val;
      logic signed [31:0] inv_val;
   } pair_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_PIV_RD,
      ST_PIV_CHK,
      ST_SC_RD,
      ST_SC_GO_A,
      ST_SC_WAIT_A,
      ST_SC_GO_I,
      ST_SC_WAIT_I,
      ST_EL_ROW,
      ST_NEXT_PIV,
      ST_EL_S_RD,
      ST_EL_S_CHK,
      ST_EL_P_RD,
      ST_EL_R_RD,
      ST_EL_MUL_A,
      ST_EL_MUL_I,
      ST_EL_CAP,
      ST_EL_WR,
      ST_OUT_RD,
      ST_OUT_LAT
   } state_type;

endpackage

// ===== rtl/core/gj_ram.sv =====
// simple synchronous ram, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps

module gj_ram #(
   parameter int ADDR_W = 6,
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/gj_div.sv =====
// iterative q16.16 divider, one quotient bit per cycle, rounded and saturated
// depends on gj_pkg
`timescale 1ns / 1ps

module gj_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [31:0]  num,
   input  logic signed [31:0]  den,
   output logic signed [31:0]  quot,
   output gj_pkg::div_stat_type stat
);

   import gj_pkg::*;

   localparam int DVD_W = 48;

   logic              busy_ff, busy_in;
   logic              fin_ff, fin_in;
   logic              done_ff, done_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic [32:0]       rem_ff, rem_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [31:0]       np_ff, np_in;
   logic              neg_ff, neg_in;
   logic signed [31:0] q_ff, q_in;

   logic [31:0]       nx, np;
   logic [32:0]       rem_sh;
   logic              take_bit;
   logic signed [DVD_W:0] q_signed;

   always_comb begin
      nx = num[31] ? 32'(-num) : 32'(num);
      np = den[31] ? 32'(-den) : 32'(den);
      rem_sh = {rem_ff[31:0], dvd_ff[DVD_W-1]};
      take_bit = (rem_sh >= {1'b0, np_ff});
      q_signed = neg_ff ? -$signed({1'b0, dvd_ff}) : $signed({1'b0, dvd_ff});

      busy_in = busy_ff;
      fin_in = 1'b0;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      np_in = np_ff;
      neg_in = neg_ff;
      q_in = q_ff;

      if (start) begin
         // dividend carries the rounding term: (|x| << 16) + |p| / 2
         dvd_in = {nx, 16'b0} + DVD_W'(np >> 1);
         rem_in = '0;
         np_in = np;
         neg_in = num[31] ^ den[31];
         cnt_in = 6'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = take_bit ? (rem_sh - {1'b0, np_ff}) : rem_sh;
         dvd_in = {dvd_ff[DVD_W-2:0], take_bit};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            fin_in = 1'b1;
         end
      end else if (fin_ff) begin
         if (q_signed > DVD_W'(Q_MAX)) begin
            q_in = Q_MAX;
         end else if (q_signed < $signed({{(DVD_W-31){1'b1}}, Q_MIN})) begin
            q_in = Q_MIN;
         end else begin
            q_in = q_signed[31:0];
         end
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff <= fin_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      np_ff <= np_in;
      neg_ff <= neg_in;
      q_ff <= q_in;
   end

   assign quot = q_ff;
   assign stat.busy = busy_ff | fin_ff;
   assign stat.done = done_ff;

endmodule

// ===== rtl/core/gj_msub.sv =====
// pipelined multiply-subtract x - round(a*b >> 16), saturated; the product and then the rounded term are registered
// depends on gj_pkg
`timescale 1ns / 1ps

module gj_msub (
   input  logic               clock,
   input  logic signed [31:0] mul_a,
   input  logic signed [31:0] mul_b,
   input  logic signed [31:0] sub_x,
   output logic signed [31:0] diff
);

   import gj_pkg::*;

   logic signed [63:0] prod_ff;
   logic signed [31:0] x1_ff, x2_ff;
   logic signed [47:0] rnd_ff, rnd_in;
   logic [63:0]        mag;
   logic [63:0]        mag_r;
   logic signed [48:0] wide;

   always_comb begin
      mag = prod_ff[63] ? 64'(-prod_ff) : 64'(prod_ff);
      mag_r = mag + 64'd32768;
      rnd_in = prod_ff[63] ? -$signed({1'b0, mag_r[62:16]}) : $signed({1'b0, mag_r[62:16]});
      wide = 49'(x2_ff) - 49'(rnd_ff);
      if (wide > 49'(Q_MAX)) begin
         diff = Q_MAX;
      end else if (wide < 49'(Q_MIN)) begin
         diff = Q_MIN;
      end else begin
         diff = wide[31:0];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      x1_ff <= sub_x;
      rnd_ff <= rnd_in;
      x2_ff <= x1_ff;
   end

endmodule

// ===== rtl/core/gauss_jordan_matrix_inverse.sv =====
// top level of the gauss-jordan inverse: sequencer, load store and working store
// depends on gj_pkg, gj_ram, gj_div, gj_msub
`timescale 1ns / 1ps

// usage
//  req channel (valid/stall): one beat loads one matrix entry (row, col, value);
//    rows or columns at or above MAX_SIZE are dropped. a beat with last_entry
//    set loads its entry and starts inverting the top-left matrix_size square.
//  csr channel (valid/ready): writes matrix_size (0 acts as 1, above MAX_SIZE
//    acts as MAX_SIZE); taken only while the block is idle.
//  rsp channel (valid/stall): the inverse in row-major order, one beat per entry,
//    last_result on the final one, zero_pivot on all of them if a pivot was 0.
//  sequencing: req_stall is low only when idle. an inversion of size n runs on
//    one divider and one multiply-subtract pipe over a single-read working ram:
//    the whole load store is copied, with the identity laid beside it; each pivot
//    row is scaled entry by entry, two divisions per entry; a forward pass clears
//    rows below each pivot and a backward pass rows above it, entry by entry.
//  reset: load store reads as zero (valid bits cleared), matrix_size = 8,
//    no result pending. a stalled result is held in the output register, the
//    sequencer waits for it before reading the next entry.
module gauss_jordan_matrix_inverse #(
   parameter int MAX_SIZE = gj_pkg::DEF_MAX_SIZE
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  gj_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output gj_pkg::rsp_type rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [3:0]      csr_wdata
);

   import gj_pkg::*;

   localparam int IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
   localparam int CNT_W = $clog2(MAX_SIZE + 1);
   localparam int ADDR_W = 2 * IDX_W;
   localparam int DEPTH = 1 << ADDR_W;

   function automatic logic [ADDR_W-1:0] rc_addr(input logic [CNT_W-1:0] r,
                                                 input logic [CNT_W-1:0] c);
      rc_addr = {r[IDX_W-1:0], c[IDX_W-1:0]};
   endfunction

   // sequencer state
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  pi_ff, pi_in;      // pivot index
   logic [CNT_W-1:0]  rr_ff, rr_in;      // target row / output row
   logic [CNT_W-1:0]  jj_ff, jj_in;      // column
   logic [ADDR_W-1:0] cp_ff, cp_in;      // copy sweep address
   logic              fwd_ff, fwd_in;    // forward pass below, else backward above
   logic              fault_ff, fault_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [3:0]        size_ff, size_in;
   logic [DEPTH-1:0]  wvalid_ff, wvalid_in;

   // operand holding registers
   logic signed [31:0] piv_ff, piv_in;
   logic signed [31:0] s_ff, s_in;
   logic signed [31:0] qa_ff, qa_in;
   logic signed [31:0] ra_ff, ra_in;
   pair_type           ent_ff, ent_in;
   pair_type           pv_ff, pv_in;
   pair_type           rv_ff, rv_in;

   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;

   // ram ports
   logic              work_we;
   logic [ADDR_W-1:0] work_waddr, work_raddr;
   logic [31:0]       work_rdata;
   logic              row_we;
   logic [ADDR_W-1:0] row_waddr, row_raddr;
   pair_type          row_wdata, row_rdata;

   // arithmetic units
   logic               div_start;
   logic signed [31:0] div_num, div_q;
   div_stat_type       div_stat;
   logic signed [31:0] mac_a, mac_b, mac_x, mac_diff;

   logic              req_take, rsp_take, ld_ok, cp_ident, last_col, last_out;
   logic [3:0]        size_clamp;
   logic [IDX_W-1:0]  cp_row, cp_col;

   gj_ram #(.ADDR_W(ADDR_W), .DATA_W(32)) u_work_ram (
      .clock   (clock),
      .wr_en   (work_we),
      .wr_addr (work_waddr),
      .wr_data (req_data.entry_value),
      .rd_addr (work_raddr),
      .rd_data (work_rdata)
   );

   gj_ram #(.ADDR_W(ADDR_W), .DATA_W(64)) u_row_ram (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (row_waddr),
      .wr_data (row_wdata),
      .rd_addr (row_raddr),
      .rd_data (row_rdata)
   );

   gj_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (piv_ff),
      .quot  (div_q),
      .stat  (div_stat)
   );

   gj_msub u_msub (
      .clock (clock),
      .mul_a (mac_a),
      .mul_b (mac_b),
      .sub_x (mac_x),
      .diff  (mac_diff)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      req_take = req_valid && !req_stall;
      rsp_take = rsp_valid_ff && !rsp_stall;
      ld_ok = ({1'b0, req_data.entry_row} < 4'(MAX_SIZE)) &&
              ({1'b0, req_data.entry_col} < 4'(MAX_SIZE));
      if (size_ff == 4'd0) begin
         size_clamp = 4'd1;
      end else if (size_ff > 4'(MAX_SIZE)) begin
         size_clamp = 4'(MAX_SIZE);
      end else begin
         size_clamp = size_ff;
      end
      cp_row = cp_ff[ADDR_W-1:IDX_W];
      cp_col = cp_ff[IDX_W-1:0];
      cp_ident = (cp_row == cp_col) && (CNT_W'(cp_row) < n_ff);
      last_col = (jj_ff == n_ff - CNT_W'(1));
      last_out = last_col && (rr_ff == n_ff - CNT_W'(1));

      state_in = state_ff;
      pi_in = pi_ff;
      rr_in = rr_ff;
      jj_in = jj_ff;
      cp_in = cp_ff;
      fwd_in = fwd_ff;
      fault_in = fault_ff;
      n_in = n_ff;
      size_in = size_ff;
      wvalid_in = wvalid_ff;
      piv_in = piv_ff;
      s_in = s_ff;
      qa_in = qa_ff;
      ra_in = ra_ff;
      ent_in = ent_ff;
      pv_in = pv_ff;
      rv_in = rv_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_take;

      work_we = 1'b0;
      work_waddr = {req_data.entry_row[IDX_W-1:0], req_data.entry_col[IDX_W-1:0]};
      work_raddr = cp_ff;
      row_we = 1'b0;
      row_waddr = rc_addr(rr_ff, jj_ff);
      row_wdata = '0;
      row_raddr = rc_addr(rr_ff, jj_ff);
      div_start = 1'b0;
      div_num = ent_ff.inv_val;
      mac_a = s_ff;
      mac_b = pv_ff.a_val;
      mac_x = rv_ff.a_val;

      if (csr_valid && csr_ready) begin
         size_in = csr_wdata;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (ld_ok) begin
                  work_we = 1'b1;
                  wvalid_in[work_waddr] = 1'b1;
               end
               if (req_data.last_entry) begin
                  n_in = CNT_W'(size_clamp);
                  cp_in = '0;
                  fault_in = 1'b0;
                  state_in = ST_COPY_RD;
               end
            end
         end
         // copy the loaded matrix and lay down the identity, a read state then a write state per entry
         ST_COPY_RD: begin
            state_in = ST_COPY_WR;
         end
         ST_COPY_WR: begin
            row_we = 1'b1;
            row_waddr = cp_ff;
            row_wdata.a_val = wvalid_ff[cp_ff] ? work_rdata : Q_ZERO;
            row_wdata.inv_val = cp_ident ? Q_ONE : Q_ZERO;
            if (cp_ff == ADDR_W'(DEPTH - 1)) begin
               pi_in = '0;
               fwd_in = 1'b1;
               state_in = ST_PIV_RD;
            end else begin
               cp_in = cp_ff + ADDR_W'(1);
               state_in = ST_COPY_RD;
            end
         end
         ST_PIV_RD: begin
            row_raddr = rc_addr(pi_ff, pi_ff);
            state_in = ST_PIV_CHK;
         end
         ST_PIV_CHK: begin
            piv_in = row_rdata.a_val;
            if (row_rdata.a_val == Q_ZERO) begin
               // zero pivot: flag it, leave the row unscaled
               fault_in = 1'b1;
               rr_in = pi_ff + CNT_W'(1);
               state_in = ST_EL_ROW;
            end else begin
               jj_in = '0;
               state_in = ST_SC_RD;
            end
         end
         // scale the pivot row by 1/pivot
         ST_SC_RD: begin
            row_raddr = rc_addr(pi_ff, jj_ff);
            state_in = ST_SC_GO_A;
         end
         ST_SC_GO_A: begin
            ent_in = row_rdata;
            div_start = 1'b1;
            div_num = row_rdata.a_val;
            state_in = ST_SC_WAIT_A;
         end
         ST_SC_WAIT_A: begin
            if (div_stat.done) begin
               qa_in = div_q;
               state_in = ST_SC_GO_I;
            end
         end
         ST_SC_GO_I: begin
            div_start = 1'b1;
            div_num = ent_ff.inv_val;
            state_in = ST_SC_WAIT_I;
         end
         ST_SC_WAIT_I: begin
            if (div_stat.done) begin
               row_we = 1'b1;
               row_waddr = rc_addr(pi_ff, jj_ff);
               row_wdata.a_val = qa_ff;
               row_wdata.inv_val = div_q;
               if (last_col) begin
                  rr_in = pi_ff + CNT_W'(1);
                  state_in = ST_EL_ROW;
               end else begin
                  jj_in = jj_ff + CNT_W'(1);
                  state_in = ST_SC_RD;
               end
            end
         end
         // forward pass walks rows below the pivot, backward pass rows above it
         ST_EL_ROW: begin
            if (fwd_ff ? (rr_ff < n_ff) : (rr_ff < pi_ff)) begin
               state_in = ST_EL_S_RD;
            end else begin
               state_in = ST_NEXT_PIV;
            end
         end
         ST_NEXT_PIV: begin
            rr_in = '0;
            jj_in = '0;
            if (fwd_ff) begin
               if (pi_ff == n_ff - CNT_W'(1)) begin
                  fwd_in = 1'b0;
                  state_in = ST_EL_ROW;
               end else begin
                  pi_in = pi_ff + CNT_W'(1);
                  state_in = ST_PIV_RD;
               end
            end else if (pi_ff == '0) begin
               state_in = ST_OUT_RD;
            end else begin
               pi_in = pi_ff - CNT_W'(1);
               state_in = ST_EL_ROW;
            end
         end
         ST_EL_S_RD: begin
            row_raddr = rc_addr(rr_ff, pi_ff);
            state_in = ST_EL_S_CHK;
         end
         ST_EL_S_CHK: begin
            s_in = row_rdata.a_val;
            if (row_rdata.a_val == Q_ZERO) begin
               rr_in = rr_ff + CNT_W'(1);
               state_in = ST_EL_ROW;
            end else begin
               jj_in = '0;
               state_in = ST_EL_P_RD;
            end
         end
         ST_EL_P_RD: begin
            row_raddr = rc_addr(pi_ff, jj_ff);
            state_in = ST_EL_R_RD;
         end
         ST_EL_R_RD: begin
            pv_in = row_rdata;
            row_raddr = rc_addr(rr_ff, jj_ff);
            state_in = ST_EL_MUL_A;
         end
         ST_EL_MUL_A: begin
            rv_in = row_rdata;
            mac_b = pv_ff.a_val;
            mac_x = row_rdata.a_val;
            state_in = ST_EL_MUL_I;
         end
         ST_EL_MUL_I: begin
            mac_b = pv_ff.inv_val;
            mac_x = rv_ff.inv_val;
            state_in = ST_EL_CAP;
         end
         ST_EL_CAP: begin
            ra_in = mac_diff;
            state_in = ST_EL_WR;
         end
         ST_EL_WR: begin
            row_we = 1'b1;
            row_waddr = rc_addr(rr_ff, jj_ff);
            row_wdata.a_val = ra_ff;
            row_wdata.inv_val = mac_diff;
            if (last_col) begin
               rr_in = rr_ff + CNT_W'(1);
               state_in = ST_EL_ROW;
            end else begin
               jj_in = jj_ff + CNT_W'(1);
               state_in = ST_EL_P_RD;
            end
         end
         // stream out the inverse, waiting while the output register is full
         ST_OUT_RD: begin
            if (!rsp_valid_ff || rsp_take) begin
               state_in = ST_OUT_LAT;
            end
         end
         ST_OUT_LAT: begin
            rsp_in.out_row = FIELD_IDX_W'(rr_ff);
            rsp_in.out_col = FIELD_IDX_W'(jj_ff);
            rsp_in.out_value = row_rdata.inv_val;
            rsp_in.zero_pivot = fault_ff;
            rsp_in.last_result = last_out;
            rsp_valid_in = 1'b1;
            if (last_out) begin
               state_in = ST_IDLE;
            end else if (last_col) begin
               jj_in = '0;
               rr_in = rr_ff + CNT_W'(1);
               state_in = ST_OUT_RD;
            end else begin
               jj_in = jj_ff + CNT_W'(1);
               state_in = ST_OUT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fault_ff <= 1'b0;
         size_ff <= DEF_MATRIX_SIZE;
         wvalid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fault_ff <= fault_in;
         size_ff <= size_in;
         wvalid_ff <= wvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pi_ff <= pi_in;
      rr_ff <= rr_in;
      jj_ff <= jj_in;
      cp_ff <= cp_in;
      fwd_ff <= fwd_in;
      n_ff <= n_in;
      piv_ff <= piv_in;
      s_ff <= s_in;
      qa_ff <= qa_in;
      ra_ff <= ra_in;
      ent_ff <= ent_in;
      pv_ff <= pv_in;
      rv_ff <= rv_in;
      rsp_ff <= rsp_in;
   end

   // output register is never overwritten while a result is still pending
   a_out_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT_LAT) |-> !rsp_valid_ff)
      else $error("result latched over a pending beat");

   // the divider is only started when idle
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider started while busy");

   // a new inversion starts with a clean pivot flag
   a_fault_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid && req_data.last_entry) |=> !fault_ff)
      else $error("pivot flag not cleared at start");

endmodule

// ===== sim/gj_inverse_checker.sv =====
// checker for the gauss-jordan inverse: watches the load, result and csr channels
// depends on gj_pkg; predicts each inverse in q16.16 and compares result beats
`timescale 1ns / 1ps

module gj_inverse_checker (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_stall,
   input  gj_pkg::req_type req_data,
   input  logic            rsp_valid,
   input  logic            rsp_stall,
   input  gj_pkg::rsp_type rsp_data,
   input  logic            csr_valid,
   input  logic            csr_ready,
   input  logic [3:0]      csr_wdata,
   output int              fail_count,
   output int              pending_count,
   output int              result_count
);
   import gj_pkg::*;

   localparam int MS = 8;

   logic signed [31:0] loaded[MS*MS];
   logic [3:0] size_reg;
   rsp_type expected_q[$];

   function automatic logic signed [31:0] sat(logic signed [63:0] v);
      if (v > 64'sd2147483647) return Q_MAX;
      if (v < -64'sd2147483648) return Q_MIN;
      return v[31:0];
   endfunction

   function automatic logic signed [63:0] qmul(logic signed [31:0] a, logic signed [31:0] b);
      logic signed [63:0] p;
      logic [63:0] m;
      p = 64'(a) * 64'(b);
      m = p < 0 ? -p : p;
      m = (m + 64'd32768) >> 16;
      return p < 0 ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic signed [31:0] qdiv(logic signed [31:0] x, logic signed [31:0] p);
      logic [63:0] nx, np, q;
      logic signed [63:0] xs, ps;
      xs = 64'(x);
      ps = 64'(p);
      nx = xs < 0 ? -xs : xs;
      np = ps < 0 ? -ps : ps;
      q = ((nx << 16) + np / 2) / np;
      return sat(((x < 0) != (p < 0)) ? -$signed(q) : $signed(q));
   endfunction

   // work out the inverse of the top-left square and queue its result beats
   task automatic predict_inverse();
      logic signed [31:0] a[MS*MS];
      logic signed [31:0] v[MS*MS];
      logic signed [31:0] p, s;
      logic bad;
      int n;
      rsp_type r;
      n = size_reg == 0 ? 1 : (size_reg > MS ? MS : int'(size_reg));
      a = loaded;
      foreach (v[k]) v[k] = Q_ZERO;
      for (int i = 0; i < n; i++) v[i*MS+i] = Q_ONE;
      bad = 1'b0;
      for (int i = 0; i < n; i++) begin
         p = a[i*MS+i];
         if (p == 0) begin
            bad = 1'b1;
         end else begin
            for (int j = 0; j < n; j++) begin
               a[i*MS+j] = qdiv(a[i*MS+j], p);
               v[i*MS+j] = qdiv(v[i*MS+j], p);
            end
         end
         for (int rr = i + 1; rr < n; rr++) begin
            s = a[rr*MS+i];
            if (s != 0)
               for (int j = 0; j < n; j++) begin
                  a[rr*MS+j] = sat(64'(a[rr*MS+j]) - qmul(s, a[i*MS+j]));
                  v[rr*MS+j] = sat(64'(v[rr*MS+j]) - qmul(s, v[i*MS+j]));
               end
         end
      end
      for (int i = n - 1; i >= 0; i--)
         for (int rr = i - 1; rr >= 0; rr--) begin
            s = a[rr*MS+i];
            if (s != 0)
               for (int j = 0; j < n; j++) begin
                  a[rr*MS+j] = sat(64'(a[rr*MS+j]) - qmul(s, a[i*MS+j]));
                  v[rr*MS+j] = sat(64'(v[rr*MS+j]) - qmul(s, v[i*MS+j]));
               end
         end
      for (int i = 0; i < n; i++)
         for (int j = 0; j < n; j++) begin
            r.out_row = i[2:0];
            r.out_col = j[2:0];
            r.out_value = v[i*MS+j];
            r.zero_pivot = bad;
            r.last_result = (i == n - 1) && (j == n - 1);
            expected_q.push_back(r);
         end
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         foreach (loaded[k]) loaded[k] = Q_ZERO;
         size_reg = DEF_MATRIX_SIZE;
         expected_q.delete();
         fail_count <= 0;
         result_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            result_count <= result_count + 1;
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result beat %p", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_q.pop_front();
               if (rsp_data !== e) begin
                  $display("%0t: mismatch expected %p actual %p", $time, e, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) begin
            loaded[req_data.entry_row*MS + req_data.entry_col] = req_data.entry_value;
            if (req_data.last_entry) predict_inverse();
         end
         // a size written on the same edge applies from the next inversion on
         if (csr_valid && csr_ready) size_reg = csr_wdata;
      end
      pending_count <= expected_q.size();
   end

endmodule

// ===== sim/gauss_jordan_matrix_inverse_tb.sv =====
// testbench top for the gauss-jordan inverse: clock, reset, load and csr stimulus, verdict
// depends on gj_pkg, gauss_jordan_matrix_inverse and gj_inverse_checker
`timescale 1ns / 1ps

module gauss_jordan_matrix_inverse_tb;
   import gj_pkg::*;

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall, csr_valid, csr_ready;
   req_type req_data;
   rsp_type rsp_data;
   logic [3:0] csr_wdata;
   int fail_count, pending_count, result_count;
   int send_gap_pct, recv_stall_pct;
   int inversions;

   gauss_jordan_matrix_inverse i_dut (.*);

   gj_inverse_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver backpressure, random per cycle
   always @(posedge clock)
      rsp_stall <= reset ? 1'b0 : ($urandom_range(99) < recv_stall_pct);

   // one load beat, with random sender gaps ahead of it; valid stays high
   // into the next beat when no gap follows
   task automatic send_entry(int row, int col, logic signed [31:0] value, bit last);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{entry_row: row[2:0], entry_col: col[2:0], entry_value: value,
                    last_entry: last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (last) inversions++;
   endtask

   // wait for all results, then for the sequencer to settle before a csr write
   task automatic drain_then_write(logic [3:0] size);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= size;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [31:0] rand_value(int kind);
      case (kind)
         0: return $signed($urandom());
         1: return $signed($urandom_range(32'h0002_0000)) - 32'sh0001_0000;
         default: return $signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
      endcase
   endfunction

   // random matrix of size n, last entry sent at a random position
   task automatic send_matrix(int n);
      int lr, lc;
      logic signed [31:0] v;
      lr = $urandom_range(n - 1);
      lc = $urandom_range(n - 1);
      for (int r = 0; r < n; r++)
         for (int c = 0; c < n; c++) begin
            if (r == lr && c == lc) continue;
            v = (r == c) ? rand_value(2) + 32'sh0008_0000 * ($urandom_range(1) ? 1 : -1)
                         : rand_value($urandom_range(9) == 0 ? 0 : 1);
            if ($urandom_range(19) == 0) v = Q_ZERO;
            send_entry(r, c, v, 1'b0);
         end
      send_entry(lr, lc, (lr == lc) ? 32'sh0004_0000 : rand_value(1), 1'b1);
   endtask

   initial begin
      int n;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_wdata = '0;
      send_gap_pct = 7;
      recv_stall_pct = 72;
      inversions = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // all-zero store at reset size: every pivot zero
      send_entry(7, 7, Q_ZERO, 1'b1);
      // size 1 with extreme values
      drain_then_write(4'd1);
      send_entry(0, 0, Q_MAX, 1'b1);
      send_entry(0, 0, Q_MIN, 1'b1);
      send_entry(0, 0, 32'sh0000_0001, 1'b1);
      send_entry(0, 0, -32'sh0000_0001, 1'b1);
      // size 0 behaves as size 1
      drain_then_write(4'd0);
      send_entry(0, 0, 32'sh0002_0000, 1'b1);
      // size above the maximum behaves as the maximum
      drain_then_write(4'd15);
      for (int i = 0; i < 8; i++) send_entry(i, i, Q_ONE, 1'b0);
      send_entry(0, 7, 32'sh7fff_0000, 1'b1);
      // size 2: zero leading entry skipped, then a zero pivot in the first row
      drain_then_write(4'd2);
      send_entry(0, 0, 32'sh0002_0000, 1'b0);
      send_entry(0, 1, -32'sh0001_0000, 1'b0);
      send_entry(1, 0, Q_ZERO, 1'b0);
      send_entry(1, 1, 32'sh0000_8000, 1'b1);
      send_entry(1, 0, 32'sh0004_0000, 1'b0);
      send_entry(1, 1, 32'sh0002_0000, 1'b1);
      send_entry(0, 0, Q_ZERO, 1'b1);

      // random phases over the three idling patterns
      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin
            send_gap_pct = 72;
            recv_stall_pct = 7;
         end else if (phase == 2) begin
            send_gap_pct = 0;
            recv_stall_pct = 0;
         end
         for (int m = 0; m < 6; m++) begin
            n = (m == 5) ? ((phase == 0) ? 8 : 6) : $urandom_range(1, 4);
            drain_then_write(n[3:0]);
            send_matrix(n);
            // some noise beats, overwriting single entries then reinverting
            if ($urandom_range(1)) begin
               send_entry($urandom_range(7), $urandom_range(7), rand_value(0), 1'b0);
               send_entry($urandom_range(n - 1), $urandom_range(n - 1), rand_value(1), 1'b1);
            end
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("covered %0d inversions and %0d result beats across sizes 0 to 15,",
               inversions, result_count);
      $display("with sender gaps and receiver stalls in both orders and without idling");
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #200ms;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== gauss_jordan_matrix_inverse.f =====
rtl/core/gj_pkg.sv
rtl/core/gj_ram.sv
rtl/core/gj_div.sv
rtl/core/gj_msub.sv
rtl/core/gauss_jordan_matrix_inverse.sv
sim/gj_inverse_checker.sv
sim/gauss_jordan_matrix_inverse_tb.sv
